// File: rtl/osfd_pkg.sv
// Shared types, constants and helper functions for the SIGNAL field decoder.
// Used by osfd_ctrl, osfd_datapath and ofdm_signal_field_decoder_top.
package osfd_pkg;

  localparam int unsigned NumSteps   = 24;
  localparam int unsigned NumStates  = 64;
  localparam int unsigned StepW      = 5;
  localparam int unsigned StateW     = 6;
  localparam int unsigned MetricW    = 10;
  localparam int unsigned CodedW     = 48;
  localparam int unsigned DecW       = 24;
  localparam int unsigned OutDataW   = 48;
  localparam int unsigned BarredFrom = 19;

  localparam logic [MetricW-1:0] Unreachable = 10'd1023;
  localparam logic [6:0]         G0Taps      = 7'h6D;
  localparam logic [6:0]         G1Taps      = 7'h4F;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusUnreach = 2'd1;
  localparam logic [1:0] StatusParity  = 2'd2;
  localparam logic [1:0] StatusRate    = 2'd3;

  typedef struct packed {
    logic             load;
    logic             acs;
    logic             barred;
    logic             tb_rd;
    logic [StepW-1:0] step;
    logic             publish;
  } osfd_cmd_t;

  function automatic logic [CodedW-1:0] deinterleave(input logic [CodedW-1:0] rx);
    logic [CodedW-1:0] code;
    code = '0;
    for (int k = 0; k < 48; k++) begin
      code[k] = rx[3 * (k % 16) + k / 16];
    end
    return code;
  endfunction

  function automatic logic [1:0] branch_cost(input logic [StateW-1:0] prev,
                                             input logic b, input logic [1:0] pair);
    logic [6:0] r;
    logic [1:0] d;
    r = {prev, b};
    d = {^(r & G1Taps), ^(r & G0Taps)} ^ pair;
    return {1'b0, d[0]} + {1'b0, d[1]};
  endfunction

  function automatic logic [MetricW-1:0] extend(input logic [MetricW-1:0] metric,
                                                input logic [StateW-1:0] prev,
                                                input logic b, input logic [1:0] pair);
    logic [MetricW-1:0] res;
    if (metric == Unreachable) begin
      res = Unreachable;
    end else begin
      res = metric + {{(MetricW-2){1'b0}}, branch_cost(prev, b, pair)};
    end
    return res;
  endfunction

endpackage

// File: rtl/ofdm_signal_field_decoder_top.sv
// Top level of the SIGNAL field decoder: stream ports, sequencer and datapath.
// Depends on osfd_pkg, osfd_ctrl and osfd_datapath.
//
//   channel  | dir | tdata fields (low bit first)
//   s_axis   | in  | coded_bits[47:0]
//   m_axis   | out | status[1:0], rate_code[5:2], psdu_length[17:6],
//            |     | decoded_bits[41:18], zero pad[47:42]
//
// After the input transfer, the ACS phase (one trellis step per cycle across 64
// lanes), 24 survivor memory reads for traceback, a drain state for the read
// latency and result registration run before the result is valid.
// One item is in flight at a time; input is taken again in the cycle after the
// result is registered. A stalled result holds the decoder in its final state.
// rst_ni clears the sequencer and valid flags asynchronously.
module ofdm_signal_field_decoder_top import osfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CodedW-1:0]   s_axis_tdata,  // coded_bits[47:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // status, rate_code, psdu_length, decoded_bits
);

  osfd_cmd_t cmd;

  osfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  osfd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .coded_bits_i (s_axis_tdata),
    .result_o     (m_axis_tdata)
  );

endmodule

// File: rtl/osfd_ctrl.sv
// Sequencer for the SIGNAL field decoder: load, 24 ACS steps, traceback, drain, publish.
// Depends on osfd_pkg; drives osfd_datapath through osfd_cmd_t.
module osfd_ctrl import osfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output osfd_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAcs   = 3'd1;
  localparam logic [2:0] StTb    = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StPub   = 3'd4;

  localparam logic [StepW-1:0] LastStep   = StepW'(NumSteps - 1);
  localparam logic [StepW-1:0] BarredStep = StepW'(BarredFrom);

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, publish;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign publish     = (state_q == StPub) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StAcs;
          cnt_d   = '0;
        end
      end
      StAcs: begin
        if (cnt_q == LastStep) begin
          state_d = StTb;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StTb: begin
        if (cnt_q == '0) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDrain: begin
        state_d = StPub;
      end
      StPub: begin
        if (publish) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.acs     = (state_q == StAcs);
    cmd_o.barred  = (cnt_q >= BarredStep);
    cmd_o.tb_rd   = (state_q == StTb);
    cmd_o.step    = cnt_q;
    cmd_o.publish = publish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/osfd_datapath.sv
// Datapath: deinterleaver, 64 parallel ACS lanes, survivor memory, traceback
// and result register. Depends on osfd_pkg; commanded by osfd_ctrl.
module osfd_datapath import osfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  osfd_cmd_t           cmd_i,
  input  logic [CodedW-1:0]   coded_bits_i,
  output logic [OutDataW-1:0] result_o
);

  logic [CodedW-1:0]    code_q;
  logic [MetricW-1:0]   pm_q [NumStates];
  logic [MetricW-1:0]   pm_d [NumStates];
  logic [NumStates-1:0] choice_d;
  logic [NumStates-1:0] surv_mem [NumSteps];
  logic [NumStates-1:0] rd_data_q;
  logic [StepW-1:0]     rd_step_q;
  logic                 rd_vld_q;
  logic [StateW-1:0]    st_q;
  logic [DecW-1:0]      dec_q;
  logic [OutDataW-1:0]  result_q;
  logic [1:0]           pair;

  assign pair = code_q[1:0];

  for (genvar s = 0; s < NumStates; s++) begin : g_acs
    localparam logic [StateW-1:0] Lo = StateW'(s / 2);
    localparam logic [StateW-1:0] Hi = Lo | 6'h20;
    localparam logic              B  = 1'(s % 2);
    logic [MetricW-1:0] c0, c1;
    assign c0 = extend(pm_q[Lo], Lo, B, pair);
    assign c1 = extend(pm_q[Hi], Hi, B, pair);
    always_comb begin
      if (cmd_i.barred && B) begin
        pm_d[s]     = Unreachable;
        choice_d[s] = 1'b0;
      end else if (c0 < c1) begin
        pm_d[s]     = c0;
        choice_d[s] = 1'b0;
      end else begin
        pm_d[s]     = c1;
        choice_d[s] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        pm_q[s] <= (s == 0) ? '0 : Unreachable;
      end else if (cmd_i.acs) begin
        pm_q[s] <= pm_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= deinterleave(coded_bits_i);
    end else if (cmd_i.acs) begin
      code_q <= {2'b00, code_q[CodedW-1:2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acs) begin
      surv_mem[cmd_i.step] <= choice_d;
    end
    if (cmd_i.tb_rd) begin
      rd_data_q <= surv_mem[cmd_i.step];
      rd_step_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.tb_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q  <= '0;
      dec_q <= '0;
    end else if (rd_vld_q) begin
      dec_q[rd_step_q] <= st_q[0];
      st_q             <= {rd_data_q[st_q], st_q[StateW-1:1]};
    end
  end

  logic [1:0]      status;
  logic [3:0]      rate;
  logic [11:0]     len;
  logic [DecW-1:0] dec_out;
  logic            unreach;

  always_comb begin
    unreach = (pm_q[0] == Unreachable);
    rate    = dec_q[3:0];
    len     = dec_q[16:5];
    dec_out = dec_q;
    if (unreach) begin
      status  = StatusUnreach;
      rate    = '0;
      len     = '0;
      dec_out = '0;
    end else if ((^dec_q[16:0]) != dec_q[17]) begin
      status = StatusParity;
    end else if (!dec_q[3]) begin
      status = StatusRate;
    end else begin
      status = StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      result_q <= {6'b0, dec_out, len, rate, status};
    end
  end

  assign result_o = result_q;

endmodule

// File: verif/osfd_header_checker.sv
// Checker for the SIGNAL field decoder: watches both stream channels, decodes every accepted
// symbol with its own trellis search and compares each result transfer field by field.
// Depends on osfd_pkg for the port widths and the status codes.
module osfd_header_checker import osfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [CodedW-1:0]   s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] TapsA  = 7'h6D;
  localparam logic [6:0] TapsB  = 7'h4F;
  localparam logic [9:0] NoPath = 10'd1023;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  rate;
    logic [11:0] psdu_len;
    logic [23:0] bits;
  } signal_hdr_t;

  signal_hdr_t expected_headers[$];

  function automatic logic [9:0] add_branch(input logic [9:0] m, input logic [5:0] prev,
                                            input logic b, input logic [1:0] pair);
    logic [6:0] r;
    logic [1:0] d;
    r = {prev, b};
    d = {^(r & TapsB), ^(r & TapsA)} ^ pair;
    if (m == NoPath) return NoPath;
    return m + 10'(d[0]) + 10'(d[1]);
  endfunction

  function automatic signal_hdr_t decode_signal_symbol(input logic [47:0] rx);
    logic [47:0] code;
    logic [9:0]  metric [64];
    logic [9:0]  nxt [64];
    logic [63:0] surv [24];
    logic [9:0]  c_lo, c_hi;
    logic [5:0]  lo, hi, st;
    logic [1:0]  pair;
    logic [23:0] dec;
    signal_hdr_t res;
    for (int k = 0; k < 48; k++) begin
      code[k] = rx[3 * (k % 16) + k / 16];
    end
    for (int s = 0; s < 64; s++) begin
      metric[s] = (s == 0) ? 10'd0 : NoPath;
    end
    for (int i = 0; i < 24; i++) begin
      pair    = code[2*i +: 2];
      surv[i] = '0;
      for (int s = 0; s < 64; s++) begin
        lo = 6'(s >> 1);
        hi = lo | 6'h20;
        if (i >= 19 && s[0]) begin
          nxt[s] = NoPath;
        end else begin
          c_lo = add_branch(metric[lo], lo, s[0], pair);
          c_hi = add_branch(metric[hi], hi, s[0], pair);
          if (c_lo < c_hi) begin
            nxt[s] = c_lo;
          end else begin
            nxt[s]     = c_hi;
            surv[i][s] = 1'b1;
          end
        end
      end
      metric = nxt;
    end
    res = '0;
    if (metric[0] == NoPath) begin
      res.status = StatusUnreach;
      return res;
    end
    st  = '0;
    dec = '0;
    for (int i = 23; i >= 0; i--) begin
      dec[i] = st[0];
      st     = {surv[i][st], st[5:1]};
    end
    res.bits     = dec;
    res.rate     = dec[3:0];
    res.psdu_len = dec[16:5];
    if (^dec[16:0] != dec[17]) begin
      res.status = StatusParity;
    end else if (!dec[3]) begin
      res.status = StatusRate;
    end else begin
      res.status = StatusOk;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    fail_count_o++;
  endtask

  task automatic check_result(input logic [OutDataW-1:0] word);
    signal_hdr_t want;
    if (expected_headers.size() == 0) begin
      report_mismatch("result transfer with no symbol pending", '0, word[31:0]);
      return;
    end
    want = expected_headers.pop_front();
    if (word[1:0] != want.status)
      report_mismatch("status", 32'(want.status), 32'(word[1:0]));
    if (word[5:2] != want.rate)
      report_mismatch("rate_code", 32'(want.rate), 32'(word[5:2]));
    if (word[17:6] != want.psdu_len)
      report_mismatch("psdu_length", 32'(want.psdu_len), 32'(word[17:6]));
    if (word[41:18] != want.bits)
      report_mismatch("decoded_bits", 32'(want.bits), 32'(word[41:18]));
    if (word[47:42] != '0)
      report_mismatch("pad bits", '0, 32'(word[47:42]));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_headers.push_back(decode_signal_symbol(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
      pending_o = expected_headers.size();
    end
  end

endmodule

// File: verif/tb_ofdm_signal_field_decoder_top.sv
// Testbench top for the SIGNAL field decoder: clock, reset, symbol stimulus and result stalls.
// Encodes headers with its own convolutional encoder and interleaver, adds bit errors and noise.
// Depends on osfd_pkg, ofdm_signal_field_decoder_top and osfd_header_checker.
module tb_ofdm_signal_field_decoder_top import osfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] TapsA = 7'h6D;
  localparam logic [6:0] TapsB = 7'h4F;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CodedW-1:0]   s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  int                  fail_count;
  int                  pending;

  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_hold    = 0;

  ofdm_signal_field_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  osfd_header_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: always ready, coin flips, or long stalls with single-cycle openings
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          rx_hold = $urandom_range(0, 40);
        end
      end
    endcase
  end

  function automatic logic [23:0] make_header(input logic [3:0] rate, input logic rsvd,
                                              input logic [11:0] len, input logic parity_ok);
    logic [23:0] h;
    h       = '0;
    h[3:0]  = rate;
    h[4]    = rsvd;
    h[16:5] = len;
    h[17]   = ^h[16:0] ^ !parity_ok;
    return h;
  endfunction

  function automatic logic [47:0] encode_symbol(input logic [23:0] hdr);
    logic [6:0]  r;
    logic [5:0]  sr;
    logic [47:0] code;
    logic [47:0] rx;
    sr = '0;
    for (int i = 0; i < 24; i++) begin
      r           = {sr, hdr[i]};
      code[2*i]   = ^(r & TapsA);
      code[2*i+1] = ^(r & TapsB);
      sr          = r[5:0];
    end
    for (int k = 0; k < 48; k++) begin
      rx[3 * (k % 16) + k / 16] = code[k];
    end
    return rx;
  endfunction

  function automatic logic [47:0] flip_bits(input logic [47:0] rx, input int n);
    logic [47:0] v;
    v = rx;
    repeat (n) v[$urandom_range(0, 47)] ^= 1'b1;
    return v;
  endfunction

  function automatic logic [47:0] random_symbol();
    int          pick;
    int          errs;
    logic [3:0]  rate;
    logic [11:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 48'({$urandom(), $urandom()});
    rate = 4'($urandom_range(0, 15));
    rate[3] = (pick >= 25);
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = '1;
      default: len = 12'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: errs = 0;
      4, 5, 6:    errs = 1;
      7, 8:       errs = 2;
      default:    errs = $urandom_range(3, 8);
    endcase
    return flip_bits(encode_symbol(make_header(rate, 1'($urandom_range(0, 1)), len,
                                               !(pick >= 25 && pick < 35))), errs);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue_symbol(input logic [47:0] sym);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= sym;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [47:0] directed_syms[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    directed_syms.push_back('0);
    directed_syms.push_back('1);
    directed_syms.push_back({24{2'b10}});
    directed_syms.push_back({24{2'b01}});
    for (int r = 8; r < 16; r++) begin
      directed_syms.push_back(encode_symbol(make_header(4'(r), 1'b0,
                                                        (r % 2) ? 12'hFFF : 12'h000, 1'b1)));
    end
    directed_syms.push_back(encode_symbol(make_header(4'hF, 1'b1, 12'hFFF, 1'b1)));
    directed_syms.push_back(encode_symbol(make_header(4'h7, 1'b0, 12'h5A5, 1'b1)));
    directed_syms.push_back(encode_symbol(make_header(4'h0, 1'b1, 12'h000, 1'b1)));
    directed_syms.push_back(encode_symbol(make_header(4'hB, 1'b0, 12'h123, 1'b0)));
    directed_syms.push_back(encode_symbol(make_header(4'h3, 1'b0, 12'hABC, 1'b0)));
    directed_syms.push_back(encode_symbol(make_header(4'hD, 1'b0, 12'h800, 1'b1)) ^ 48'h1);
    directed_syms.push_back(encode_symbol(make_header(4'h9, 1'b1, 12'h001, 1'b1))
                            ^ 48'h8000_0000_0000);
    directed_syms.push_back(flip_bits(encode_symbol(make_header(4'hC, 1'b0, 12'h3FF, 1'b1)), 6));
    directed_syms.push_back(flip_bits(encode_symbol(make_header(4'hA, 1'b1, 12'hC00, 1'b1)), 2));
    directed_syms.push_back(48'hFFFF_0000_FFFF);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_syms[i]) issue_symbol(directed_syms[i]);
    drain_results();

    for (int n = 0; n < 1580; n++) begin
      issue_symbol(random_symbol());
      if (n % 400 == 399) drain_results();
    end

    drain_results();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: ofdm_signal_field_decoder_top.f
rtl/osfd_pkg.sv
rtl/osfd_ctrl.sv
rtl/osfd_datapath.sv
rtl/ofdm_signal_field_decoder_top.sv
verif/osfd_header_checker.sv
verif/tb_ofdm_signal_field_decoder_top.sv
